>>> src/nmea_chk_pkg.sv
// shared types, constants and helpers for the nmea sentence checksum checker
package nmea_chk_pkg;

  localparam int unsigned IDX_W     = 7;
  localparam int unsigned MAX_INDEX = 75;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_NO_DOLLAR = 3'd1,
    VERDICT_NO_STAR   = 3'd2,
    VERDICT_TOO_LONG  = 3'd3,
    VERDICT_MISMATCH  = 3'd4
  } verdict_t;

  // upper-case ascii hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    logic [7:0] wide;
    wide = {4'h0, nibble};
    if (nibble < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

>>> src/nmea_chk_if.sv
// valid/ready channels for sentence characters and checksum verdicts
interface nmea_chk_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       begins_string;

  modport source (output valid, output char_byte, output begins_string, input ready);
  modport sink (input valid, input char_byte, input begins_string, output ready);
endinterface

interface nmea_chk_result_if;
  logic       valid;
  logic       ready;
  logic       sentence_ok;
  logic [2:0] verdict;
  logic [7:0] computed_sum;

  modport source (output valid, output sentence_ok, output verdict, output computed_sum,
                  input ready);
  modport sink (input valid, input sentence_ok, input verdict, input computed_sum,
                output ready);
endinterface

>>> src/nmea_checksum_checker.sv
// nmea 0183 sentence checksum checker, one character item per cycle unless a waiting verdict is not taken
// output: a verdict appears on results in the cycle after the character item that decides it
// throughput: one character item per cycle; the only limit is the single result register,
// which takes a new verdict in the same cycle the waiting one is taken
// reset: synchronous rst returns the parser to idle with a cleared sum and no result pending
module nmea_checksum_checker (
  input  logic                      clk,
  input  logic                      rst,
  nmea_chk_char_if.sink             chars,
  nmea_chk_result_if.source         results
);

  nmea_chk_pkg::phase_t   phase;
  nmea_chk_pkg::phase_t   phase_next;
  logic [7:0]             running_xor;
  logic [7:0]             running_xor_next;
  logic [nmea_chk_pkg::IDX_W-1:0] char_index;
  logic [nmea_chk_pkg::IDX_W-1:0] char_index_next;
  logic [7:0]             first_hex_char;
  logic [7:0]             first_hex_char_next;

  logic                   emit;
  nmea_chk_pkg::verdict_t verdict_code;
  logic                   accept;
  logic                   hi_match;
  logic                   lo_match;

  // the result register frees its slot in the same cycle it is taken
  assign chars.ready = !results.valid || results.ready;
  assign accept      = chars.valid && chars.ready;

  assign hi_match = first_hex_char == nmea_chk_pkg::hex_char(running_xor[7:4]);
  assign lo_match = chars.char_byte == nmea_chk_pkg::hex_char(running_xor[3:0]);

  always_comb begin
    phase_next          = phase;
    running_xor_next    = running_xor;
    char_index_next     = char_index;
    first_hex_char_next = first_hex_char;
    emit                = 1'b0;
    verdict_code        = nmea_chk_pkg::VERDICT_OK;

    if (chars.begins_string) begin
      running_xor_next    = 8'h00;
      char_index_next     = '0;
      first_hex_char_next = 8'h00;
      if (chars.char_byte != nmea_chk_pkg::CHAR_DOLLAR) begin
        emit         = 1'b1;
        verdict_code = nmea_chk_pkg::VERDICT_NO_DOLLAR;
      end else begin
        phase_next      = nmea_chk_pkg::PH_BODY;
        char_index_next = nmea_chk_pkg::IDX_W'(1);
      end
    end else begin
      unique case (phase)
        nmea_chk_pkg::PH_BODY: begin
          if (char_index >= nmea_chk_pkg::IDX_W'(nmea_chk_pkg::MAX_INDEX)) begin
            emit         = 1'b1;
            verdict_code = nmea_chk_pkg::VERDICT_TOO_LONG;
          end else if (chars.char_byte == nmea_chk_pkg::CHAR_NUL) begin
            emit         = 1'b1;
            verdict_code = nmea_chk_pkg::VERDICT_NO_STAR;
          end else if (chars.char_byte == nmea_chk_pkg::CHAR_STAR) begin
            phase_next = nmea_chk_pkg::PH_HEX1;
          end else begin
            running_xor_next = running_xor ^ chars.char_byte;
            char_index_next  = char_index + nmea_chk_pkg::IDX_W'(1);
          end
        end
        nmea_chk_pkg::PH_HEX1: begin
          first_hex_char_next = chars.char_byte;
          // a nul right after the star ends the string
          if (chars.char_byte == nmea_chk_pkg::CHAR_NUL) begin
            emit         = 1'b1;
            verdict_code = nmea_chk_pkg::VERDICT_MISMATCH;
          end else begin
            phase_next = nmea_chk_pkg::PH_HEX2;
          end
        end
        nmea_chk_pkg::PH_HEX2: begin
          emit         = 1'b1;
          verdict_code = (hi_match && lo_match) ? nmea_chk_pkg::VERDICT_OK
                                                : nmea_chk_pkg::VERDICT_MISMATCH;
        end
        nmea_chk_pkg::PH_IDLE: begin
          phase_next = nmea_chk_pkg::PH_IDLE;
        end
        default: begin
          phase_next = nmea_chk_pkg::PH_IDLE;
        end
      endcase
    end

    if (emit) begin
      phase_next = nmea_chk_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= nmea_chk_pkg::PH_IDLE;
      running_xor    <= 8'h00;
      char_index     <= '0;
      first_hex_char <= 8'h00;
    end else if (accept) begin
      phase          <= phase_next;
      running_xor    <= running_xor_next;
      char_index     <= char_index_next;
      first_hex_char <= first_hex_char_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept && emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      results.sentence_ok  <= verdict_code == nmea_chk_pkg::VERDICT_OK;
      results.verdict      <= verdict_code;
      results.computed_sum <= running_xor_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a flagged byte other than '$' gives its verdict in the next cycle
  a_no_dollar_verdict: assert property (@(posedge clk) disable iff (rst)
    accept && chars.begins_string && chars.char_byte != nmea_chk_pkg::CHAR_DOLLAR
    |=> results.valid && results.verdict == nmea_chk_pkg::VERDICT_NO_DOLLAR
        && results.computed_sum == 8'h00)
    else $error("missing no-dollar verdict");

  // a good start opens a fresh body
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && chars.begins_string && chars.char_byte == nmea_chk_pkg::CHAR_DOLLAR
    |=> phase == nmea_chk_pkg::PH_BODY && running_xor == 8'h00
        && char_index == nmea_chk_pkg::IDX_W'(1))
    else $error("start did not reset the sentence state");

  // the body index never passes the length limit
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    phase == nmea_chk_pkg::PH_BODY
    |-> char_index <= nmea_chk_pkg::IDX_W'(nmea_chk_pkg::MAX_INDEX))
    else $error("char index beyond limit");
`endif

endmodule
